[design/imu_fd_pkg.sv]
package imu_fd_pkg;

  // Frame layout: two header bytes, sixteen body bytes, one checksum byte
  localparam int unsigned FRAME_BYTES = 19;
  localparam logic [7:0] HDR_BYTE = 8'hAA;

  // Phase codes of the frame tracker
  localparam logic [4:0] PH_HUNT      = 5'd0;
  localparam logic [4:0] PH_HDR2      = 5'd1;
  localparam logic [4:0] PH_BODY0     = 5'd2;
  localparam logic [4:0] PH_LO_FIRST  = 5'd3;
  localparam logic [4:0] PH_LO_LAST   = 5'd13;
  localparam logic [4:0] PH_HI_FIRST  = 5'd4;
  localparam logic [4:0] PH_HI_LAST   = 5'd14;
  localparam logic [4:0] PH_CSUM      = 5'(FRAME_BYTES - 1);

  // Number of converted words and the first acceleration word
  localparam int unsigned NUM_WORDS   = 6;
  localparam logic [2:0]  WORD_ACCEL0 = 3'd3;

  // Reciprocals for exact truncating division of the magnitude of a 16-bit signed value:
  // floor(x / 100) = (x * 5243) >> 19, floor(x / 1000) = (x * 33555) >> 25
  localparam logic [15:0] ANGLE_RECIP = 16'd5243;
  localparam logic [15:0] ACCEL_RECIP = 16'd33555;
  localparam int unsigned ANGLE_SHIFT = 19;
  localparam int unsigned ACCEL_SHIFT = 25;

  // floor(q * 9.80665) for q in 0..32
  function automatic logic [8:0] accel_scale(input logic [5:0] q);
    logic [8:0] r;
    unique case (q)
      6'd0:  r = 9'd0;
      6'd1:  r = 9'd9;
      6'd2:  r = 9'd19;
      6'd3:  r = 9'd29;
      6'd4:  r = 9'd39;
      6'd5:  r = 9'd49;
      6'd6:  r = 9'd58;
      6'd7:  r = 9'd68;
      6'd8:  r = 9'd78;
      6'd9:  r = 9'd88;
      6'd10: r = 9'd98;
      6'd11: r = 9'd107;
      6'd12: r = 9'd117;
      6'd13: r = 9'd127;
      6'd14: r = 9'd137;
      6'd15: r = 9'd147;
      6'd16: r = 9'd156;
      6'd17: r = 9'd166;
      6'd18: r = 9'd176;
      6'd19: r = 9'd186;
      6'd20: r = 9'd196;
      6'd21: r = 9'd205;
      6'd22: r = 9'd215;
      6'd23: r = 9'd225;
      6'd24: r = 9'd235;
      6'd25: r = 9'd245;
      6'd26: r = 9'd254;
      6'd27: r = 9'd264;
      6'd28: r = 9'd274;
      6'd29: r = 9'd284;
      6'd30: r = 9'd294;
      6'd31: r = 9'd304;
      6'd32: r = 9'd313;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[design/imu_fd_conv.sv]
module imu_fd_conv (
  input  logic signed [15:0] raw,
  input  logic               is_accel,
  output logic signed [9:0]  value
);
  import imu_fd_pkg::*;

  logic [16:0] mag;
  logic [15:0] recip;
  logic [30:0] prod;
  logic [8:0]  angle_mag;
  logic [8:0]  accel_mag;
  logic [8:0]  res_mag;

  // Take the magnitude; 32768 needs the 17th bit
  assign mag = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};

  // One shared multiply by the reciprocal of 100 or 1000
  assign recip = is_accel ? ACCEL_RECIP : ANGLE_RECIP;
  assign prod  = 31'(mag) * 31'(recip);

  assign angle_mag = prod[ANGLE_SHIFT +: 9];
  assign accel_mag = accel_scale(prod[ACCEL_SHIFT +: 6]);
  assign res_mag   = is_accel ? accel_mag : angle_mag;

  // Restore the sign; truncation toward zero holds on the magnitude
  assign value = raw[15] ? $signed(10'd0 - {1'b0, res_mag}) : $signed({1'b0, res_mag});

endmodule

[design/imu_frame_decoder.sv]
// When the checksum byte in the input register advances, out_valid and the result
// register load at that edge; while a held result is stalled, that byte waits there.
// One byte per cycle unless a stalled result holds the checksum byte; one multiplier
// converts each word as its high byte passes, so the checksum byte only loads results.
// Reset clears the frame phase, the running sum and both valid flags.
module imu_frame_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [9:0] yaw_deg,
  output logic signed [9:0] pitch_deg,
  output logic signed [9:0] roll_deg,
  output logic signed [9:0] accel_x_ms2,
  output logic signed [9:0] accel_y_ms2,
  output logic signed [9:0] accel_z_ms2,
  output logic              checksum_ok
);
  import imu_fd_pkg::*;

  logic              in_reg_valid;
  logic [7:0]        in_reg_byte;
  logic [4:0]        frame_phase;
  logic [7:0]        running_sum;
  logic [7:0]        lo_byte;
  logic signed [9:0] conv [NUM_WORDS];

  logic              emit;
  logic              advance;
  logic              lo_phase;
  logic              hi_phase;
  logic [2:0]        word_idx;
  logic signed [9:0] conv_value;

  // Decode the byte held in the input register
  assign emit     = (frame_phase == PH_CSUM);
  assign advance  = in_reg_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  assign lo_phase = (frame_phase >= PH_LO_FIRST) && (frame_phase <= PH_LO_LAST)
                    && frame_phase[0];
  assign hi_phase = (frame_phase >= PH_HI_FIRST) && (frame_phase <= PH_HI_LAST)
                    && !frame_phase[0];
  assign word_idx = frame_phase[3:1] - 3'd2;

  imu_fd_conv u_conv (
    .raw      ($signed({in_reg_byte, lo_byte})),
    .is_accel (word_idx >= WORD_ACCEL0),
    .value    (conv_value)
  );

  // Control: input register, frame phase, checksum sum, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      frame_phase  <= PH_HUNT;
      running_sum  <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        priority if (frame_phase == PH_HUNT) begin
          if (in_reg_byte == HDR_BYTE) begin
            frame_phase <= PH_HDR2;
          end
        end else if (frame_phase == PH_HDR2) begin
          if (in_reg_byte == HDR_BYTE) begin
            frame_phase <= PH_BODY0;
            running_sum <= 8'd0;
          end else begin
            frame_phase <= PH_HUNT;
          end
        end else if (frame_phase < PH_CSUM) begin
          running_sum <= running_sum + in_reg_byte;
          frame_phase <= frame_phase + 5'd1;
        end else begin
          // checksum byte, or an unreachable phase: back to hunting
          frame_phase <= PH_HUNT;
          running_sum <= 8'd0;
        end
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: input byte, word low byte, converted words, result fields
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= rx_byte;
    end
    if (advance && lo_phase) begin
      lo_byte <= in_reg_byte;
    end
    if (advance && hi_phase) begin
      conv[word_idx] <= conv_value;
    end
    if (advance && emit) begin
      yaw_deg     <= conv[0];
      pitch_deg   <= conv[1];
      roll_deg    <= conv[2];
      accel_x_ms2 <= conv[3];
      accel_y_ms2 <= conv[4];
      accel_z_ms2 <= conv[5];
      checksum_ok <= (running_sum == in_reg_byte);
    end
  end

endmodule
